// ===== hw/rtl/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int unsigned EDGE_COUNT_W = 7;
  localparam int unsigned GAP_W        = 20;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned WIN_W        = 14;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [EDGE_COUNT_W-1:0] EDGES_FULL = 7'd68;
  localparam logic [EDGE_COUNT_W-1:0] EDGE_LEAD  = 7'd1;
  localparam logic [EDGE_COUNT_W-1:0] EDGE_SPACE = 7'd2;
  localparam logic [EDGE_COUNT_W-1:0] EDGE_LAST  = 7'd66;
  localparam logic [EDGE_COUNT_W-1:0] EDGE_DATA0 = 7'd4;

  localparam logic [GAP_W-1:0] GAP_RESET = 20'd100000;

  localparam logic [WIN_W-1:0] LEAD_MARK_LO  = 14'd8500;
  localparam logic [WIN_W-1:0] LEAD_MARK_HI  = 14'd9500;
  localparam logic [WIN_W-1:0] LEAD_SPACE_LO = 14'd3500;
  localparam logic [WIN_W-1:0] LEAD_SPACE_HI = 14'd5500;
  localparam logic [WIN_W-1:0] RPT_SPACE_LO  = 14'd1250;
  localparam logic [WIN_W-1:0] RPT_SPACE_HI  = 14'd3250;
  localparam logic [WIN_W-1:0] SHORT_LO      = 14'd360;
  localparam logic [WIN_W-1:0] SHORT_HI      = 14'd760;
  localparam logic [WIN_W-1:0] LONG_LO       = 14'd1190;
  localparam logic [WIN_W-1:0] LONG_HI       = 14'd2190;

  localparam logic [7:0]        CHECK_SUM = 8'hFF;
  localparam logic [CODE_W-1:0] CODE_RPT  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [EDGE_COUNT_W-1:0] edge_count;
    logic                    repeat_locked;
    logic [CODE_W-1:0]       code_bits;
    logic                    bit_failed;
  } necir_state_t;

  typedef struct packed {
    logic              valid;
    logic              frame_ok;
    logic [CODE_W-1:0] code;
  } necir_result_t;

endpackage

// ===== hw/rtl/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// A read word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register feeds the decode logic
// and the result register, and stalls only on a read while a result waits.
// Reset: synchronous, active low; clears the frame state and sets the gap
// limit to 100000 us.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [necir_pkg::GAP_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic                          in_line_level,
  input  logic [necir_pkg::STAMP_W-1:0] in_edge_time_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_ok,
  output logic [necir_pkg::CODE_W-1:0]  out_code
);

  logic                          s1_v_r;
  logic [1:0]                    s1_mode_r;
  logic                          s1_level_r;
  logic [necir_pkg::STAMP_W-1:0] s1_time_r;
  logic [necir_pkg::GAP_W-1:0]   gap_limit_r;
  necir_pkg::necir_state_t       st_r;
  necir_pkg::necir_state_t       st_nxt;
  logic [TIME_BITS-1:0]          prev_time_r;
  logic [TIME_BITS-1:0]          prev_time_nxt;
  necir_pkg::necir_result_t      res;
  logic                          out_valid_r;
  logic                          out_ok_r;
  logic [necir_pkg::CODE_W-1:0]  out_code_r;
  logic                          adv;

  necir_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .st            (st_r),
    .prev_time     (prev_time_r),
    .gap_limit     (gap_limit_r),
    .mode          (s1_mode_r),
    .level         (s1_level_r),
    .stamp         (s1_time_r),
    .st_nxt        (st_nxt),
    .prev_time_nxt (prev_time_nxt),
    .res           (res)
  );

  assign adv      = s1_v_r && (!res.valid || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gap_limit_r <= necir_pkg::GAP_RESET;
      st_r        <= '0;
      prev_time_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        gap_limit_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        st_r        <= st_nxt;
        prev_time_r <= prev_time_nxt;
      end
      if (adv && res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= in_mode;
      s1_level_r <= in_line_level;
      s1_time_r  <= in_edge_time_us;
    end
    if (adv && res.valid) begin
      out_ok_r   <= res.frame_ok;
      out_code_r <= res.code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_frame_ok = out_ok_r;
  assign out_code     = out_code_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.edge_count <= necir_pkg::EDGES_FULL)
    else $error("edge count beyond full frame");

  a_repeat_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.repeat_locked |-> (st_r.edge_count == 7'd3))
    else $error("repeat locked without leader count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r && (s1_mode_r == necir_pkg::MODE_READ)))
    else $error("result without a read word");

endmodule

// ===== hw/rtl/necir_step.sv =====
// ----------------------------------------------------------------------------
// necir_step
// Next-state and read-result logic for one registered decoder word.
// ----------------------------------------------------------------------------
module necir_step #(
  parameter int TIME_BITS = 32
) (
  input  necir_pkg::necir_state_t      st,
  input  logic [TIME_BITS-1:0]         prev_time,
  input  logic [necir_pkg::GAP_W-1:0]  gap_limit,
  input  logic [1:0]                   mode,
  input  logic                         level,
  input  logic [necir_pkg::STAMP_W-1:0] stamp,
  output necir_pkg::necir_state_t      st_nxt,
  output logic [TIME_BITS-1:0]         prev_time_nxt,
  output necir_pkg::necir_result_t     res
);

  function automatic logic win(input logic [TIME_BITS-1:0] d,
                               input logic [necir_pkg::WIN_W-1:0] lo,
                               input logic [necir_pkg::WIN_W-1:0] hi);
    logic [TIME_BITS-1:0] lo_w;
    logic [TIME_BITS-1:0] hi_w;
    lo_w = TIME_BITS'(lo);
    hi_w = TIME_BITS'(hi);
    return (d > lo_w) && (d < hi_w);
  endfunction

  logic [TIME_BITS+necir_pkg::STAMP_W-1:0] stamp_ext;
  logic [TIME_BITS-1:0]                    t;
  logic [TIME_BITS-1:0]                    fwd;
  logic [TIME_BITS-1:0]                    back;
  logic [TIME_BITS-1:0]                    gap_w;
  logic [necir_pkg::EDGE_COUNT_W-1:0]      k;
  logic [necir_pkg::EDGE_COUNT_W-1:0]      kd;
  logic [4:0]                              j;
  logic [4:0]                              pos;
  logic [8:0]                              sum;

  assign stamp_ext = {TIME_BITS'(0), stamp};
  assign t         = stamp_ext[TIME_BITS-1:0];
  assign fwd       = t - prev_time;
  assign back      = prev_time - t;
  assign gap_w     = TIME_BITS'(gap_limit);
  assign k         = st.edge_count;
  assign kd        = k - necir_pkg::EDGE_DATA0;
  assign j         = kd[5:1];
  assign sum       = {1'b0, st.code_bits[15:8]} + {1'b0, st.code_bits[7:0]};

  always_comb begin
    if (j < 5'd16) begin
      pos = j + 5'd16;
    end else if (j < 5'd24) begin
      pos = j - 5'd8;
    end else begin
      pos = j - 5'd24;
    end
  end

  always_comb begin
    st_nxt        = st;
    prev_time_nxt = prev_time;
    res           = '0;
    case (mode)
      necir_pkg::MODE_EDGE: begin
        if (!st.repeat_locked && (k < necir_pkg::EDGES_FULL)) begin
          if (level != k[0]) begin
            st_nxt.edge_count = '0;
          end else if (k == '0) begin
            st_nxt.code_bits  = '0;
            st_nxt.bit_failed = 1'b0;
            st_nxt.edge_count = necir_pkg::EDGE_LEAD;
            prev_time_nxt     = t;
          end else if ((fwd > gap_w) && (back > gap_w)) begin
            st_nxt.edge_count = '0;
          end else begin
            prev_time_nxt     = t;
            st_nxt.edge_count = k + 7'd1;
            if (k == necir_pkg::EDGE_LEAD) begin
              if (!win(fwd, necir_pkg::LEAD_MARK_LO, necir_pkg::LEAD_MARK_HI)) begin
                st_nxt.edge_count = '0;
              end
            end else if (k == necir_pkg::EDGE_SPACE) begin
              if (win(fwd, necir_pkg::RPT_SPACE_LO, necir_pkg::RPT_SPACE_HI)) begin
                st_nxt.repeat_locked = 1'b1;
              end else if (!win(fwd, necir_pkg::LEAD_SPACE_LO,
                                necir_pkg::LEAD_SPACE_HI)) begin
                st_nxt.edge_count = '0;
              end
            end else if ((k <= necir_pkg::EDGE_LAST) && !st.bit_failed) begin
              if (k[0]) begin
                if (!win(fwd, necir_pkg::SHORT_LO, necir_pkg::SHORT_HI)) begin
                  st_nxt.bit_failed = 1'b1;
                end
              end else if (win(fwd, necir_pkg::LONG_LO, necir_pkg::LONG_HI)) begin
                st_nxt.code_bits[pos] = 1'b1;
              end else if (!win(fwd, necir_pkg::SHORT_LO, necir_pkg::SHORT_HI)) begin
                st_nxt.bit_failed = 1'b1;
              end
            end
          end
        end
      end
      necir_pkg::MODE_RESET: begin
        st_nxt.edge_count    = '0;
        st_nxt.repeat_locked = 1'b0;
      end
      necir_pkg::MODE_READ: begin
        res.valid = 1'b1;
        if (st.repeat_locked || (k >= necir_pkg::EDGES_FULL)) begin
          if (st.repeat_locked) begin
            res.frame_ok = 1'b1;
            res.code     = necir_pkg::CODE_RPT;
          end else begin
            res.frame_ok = !st.bit_failed && (sum == {1'b0, necir_pkg::CHECK_SUM});
            res.code     = st.code_bits;
          end
          st_nxt = '0;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== tb/nec_ir_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_tb
// Drives timestamped line edges, reads and receiver resets into the NEC frame
// decoder and checks every read result against a cycle-free decode model, or
// for scripted reads against the script. A short scripted sequence covers reset,
// repeat codes, timestamp wrap, long gaps, backward time and bad leaders; random
// clean, repeat and damaged frames and noise follow under several gap limits,
// with bursty input traffic, a stalling output side and one long output hold.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int WORDS_TARGET  = 450;

  typedef struct packed {
    logic        ok;
    logic [31:0] code;
  } read_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        lvl;
    logic [31:0] stamp;
    logic        typed;
    logic        ok;
    logic [31:0] code;
  } script_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic [necir_pkg::GAP_W-1:0]       cfg_wr_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        in_mode;
  logic                              in_line_level;
  logic [necir_pkg::STAMP_W-1:0]     in_edge_time_us;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_frame_ok;
  logic [necir_pkg::CODE_W-1:0]      out_code;

  logic                              word_typed;
  logic                              typed_ok;
  logic [31:0]                       typed_code;

  logic [6:0]                        nec_edges;
  logic                              rpt_locked;
  logic [31:0]                       last_stamp;
  logic [31:0]                       code_acc;
  logic                              bad_bit;
  logic [necir_pkg::GAP_W-1:0]       gap_now;

  read_result_t                      read_results_due[$];
  int                                errors;
  int                                words_sent;
  int                                results_checked;
  int                                good_results;
  int                                burst_left;
  bit                                no_gaps;
  bit                                hold_req;
  bit                                hold_active;
  logic [31:0]                       now_us;

  script_row_t script [0:24] = '{
    '{necir_pkg::MODE_READ,  1'b0, 32'd0,          1'b1, 1'b0, 32'd0},
    '{MODE_NONE,             1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_RESET, 1'b0, 32'd0,          1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd1234,       1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'hFFFF_F000,  1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd4904,       1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd7154,       1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd7714,       1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_READ,  1'b1, 32'd7800,       1'b1, 1'b1, necir_pkg::CODE_RPT},
    '{necir_pkg::MODE_READ,  1'b0, 32'd7900,       1'b1, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd0,          1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd200000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd300000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd291000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd400000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd409000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd415000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_READ,  1'b0, 32'd416000,     1'b1, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd500000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd509000,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b0, 32'd513500,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_EDGE,  1'b1, 32'd514060,     1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_READ,  1'b1, 32'd514100,     1'b1, 1'b0, 32'd0},
    '{necir_pkg::MODE_RESET, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{necir_pkg::MODE_READ,  1'b0, 32'd0,          1'b1, 1'b0, 32'd0}
  };

  nec_ir_frame_decoder #(
    .TIME_BITS(32)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_line_level   (in_line_level),
    .in_edge_time_us (in_edge_time_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_ok    (out_frame_ok),
    .out_code        (out_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic in_window(input logic [31:0] d,
                                     input logic [necir_pkg::WIN_W-1:0] lo,
                                     input logic [necir_pkg::WIN_W-1:0] hi);
    return (32'(lo) < d) && (d < 32'(hi));
  endfunction

  function automatic void decode_word(input logic [1:0] mode, input logic lvl,
                                      input logic [31:0] stamp, output logic got,
                                      output logic ok, output logic [31:0] code);
    logic [31:0] fwd;
    logic [31:0] back;
    logic [6:0]  k;
    int unsigned j;
    int unsigned pos;
    logic [8:0]  sum;
    got = 1'b0;
    ok = 1'b0;
    code = '0;
    k = nec_edges;
    if (mode == necir_pkg::MODE_EDGE) begin
      if (!rpt_locked && k < necir_pkg::EDGES_FULL) begin
        fwd = stamp - last_stamp;
        back = last_stamp - stamp;
        if (lvl != k[0]) begin
          nec_edges = '0;
        end else if (k == 0) begin
          code_acc = '0;
          bad_bit = 1'b0;
          last_stamp = stamp;
          nec_edges = 7'd1;
        end else if (fwd > {12'd0, gap_now} && back > {12'd0, gap_now}) begin
          nec_edges = '0;
        end else begin
          last_stamp = stamp;
          nec_edges = k + 7'd1;
          if (k == necir_pkg::EDGE_LEAD) begin
            if (!in_window(fwd, necir_pkg::LEAD_MARK_LO, necir_pkg::LEAD_MARK_HI))
              nec_edges = '0;
          end else if (k == necir_pkg::EDGE_SPACE) begin
            if (in_window(fwd, necir_pkg::RPT_SPACE_LO, necir_pkg::RPT_SPACE_HI))
              rpt_locked = 1'b1;
            else if (!in_window(fwd, necir_pkg::LEAD_SPACE_LO, necir_pkg::LEAD_SPACE_HI))
              nec_edges = '0;
          end else if (k <= necir_pkg::EDGE_LAST && !bad_bit) begin
            if (k[0]) begin
              if (!in_window(fwd, necir_pkg::SHORT_LO, necir_pkg::SHORT_HI)) bad_bit = 1'b1;
            end else begin
              j = 32'((k - necir_pkg::EDGE_DATA0) >> 1);
              pos = (j < 16) ? 16 + j : (j < 24) ? j - 8 : j - 24;
              if (in_window(fwd, necir_pkg::LONG_LO, necir_pkg::LONG_HI))
                code_acc[pos] = 1'b1;
              else if (!in_window(fwd, necir_pkg::SHORT_LO, necir_pkg::SHORT_HI))
                bad_bit = 1'b1;
            end
          end
        end
      end
    end else if (mode == necir_pkg::MODE_RESET) begin
      nec_edges = '0;
      rpt_locked = 1'b0;
    end else if (mode == necir_pkg::MODE_READ) begin
      got = 1'b1;
      if (rpt_locked) begin
        ok = 1'b1;
        code = necir_pkg::CODE_RPT;
      end else if (k >= necir_pkg::EDGES_FULL) begin
        sum = {1'b0, code_acc[15:8]} + {1'b0, code_acc[7:0]};
        ok = !bad_bit && (sum == {1'b0, necir_pkg::CHECK_SUM});
        code = code_acc;
      end
      if (rpt_locked || k >= necir_pkg::EDGES_FULL) begin
        nec_edges = '0;
        rpt_locked = 1'b0;
        code_acc = '0;
        bad_bit = 1'b0;
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    logic         got;
    logic         ok;
    logic [31:0]  code;
    read_result_t due;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_word(in_mode, in_line_level, in_edge_time_us, got, ok, code);
        if (got) begin
          if (word_typed) read_results_due.push_back('{typed_ok, typed_code});
          else read_results_due.push_back('{ok, code});
        end
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (out_frame_ok) good_results++;
        if (read_results_due.size() == 0) begin
          $display("%0t tb: result with nothing pending, frame_ok %0b code %h",
                   $time, out_frame_ok, out_code);
          errors++;
        end else begin
          due = read_results_due.pop_front();
          if (out_frame_ok !== due.ok) begin
            $display("%0t tb: frame_ok mismatch, expected %0b, actual %0b",
                     $time, due.ok, out_frame_ok);
            errors++;
          end
          if (out_code !== due.code) begin
            $display("%0t tb: code mismatch, expected %h, actual %h",
                     $time, due.code, out_code);
            errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t tb: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : receiver
    int kind;
    int span;
    int c;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_active = 1'b0;
        hold_req = 1'b0;
      end else begin
        kind = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        for (c = 0; c < span; c++) begin
          @(negedge clk);
          case (kind)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= c[1];
          endcase
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic lvl, input logic [31:0] stamp,
                           input logic typed, input logic ok, input logic [31:0] code);
    int idle;
    if (!no_gaps && burst_left == 0) begin
      idle = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_line_level <= lvl;
    in_edge_time_us <= stamp;
    word_typed <= typed;
    typed_ok <= ok;
    typed_code <= code;
    if (mode != MODE_NONE) words_sent++;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  task automatic send_edge(input logic lvl, input logic [31:0] stamp);
    send_item(necir_pkg::MODE_EDGE, lvl, stamp, 1'b0, 1'b0, '0);
  endtask

  task automatic send_read();
    send_item(necir_pkg::MODE_READ, 1'($urandom_range(0, 1)), $urandom, 1'b0, 1'b0, '0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (read_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gap_limit(input logic [necir_pkg::GAP_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    gap_now = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wire_bits holds the frame in air order: bit 0 goes first
  task automatic send_frame(input logic [31:0] wire_bits, input int break_at);
    int          i;
    int          flaw;
    logic        lvl;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    logic [31:0] stamp;
    flaw = $urandom_range(0, 7);
    now_us = now_us + $urandom_range(15000, 150000);
    send_edge(1'b0, now_us);
    for (i = 1; i < 68; i++) begin
      lvl = i[0];
      if (i == 1) begin
        lo = 32'(necir_pkg::LEAD_MARK_LO);
        hi = 32'(necir_pkg::LEAD_MARK_HI);
      end else if (i == 2) begin
        lo = 32'(necir_pkg::LEAD_SPACE_LO);
        hi = 32'(necir_pkg::LEAD_SPACE_HI);
      end else if (i[0] || !wire_bits[(i - 4) / 2]) begin
        lo = 32'(necir_pkg::SHORT_LO);
        hi = 32'(necir_pkg::SHORT_HI);
      end else begin
        lo = 32'(necir_pkg::LONG_LO);
        hi = 32'(necir_pkg::LONG_HI);
      end
      span = $urandom_range(lo + 1, hi - 1);
      stamp = now_us + span;
      if (i == break_at) begin
        case (flaw)
          0: stamp = now_us + lo;
          1: stamp = now_us + hi;
          2: stamp = now_us + $urandom_range(0, 12000);
          3: lvl = ~lvl;
          4: stamp = now_us + 32'(gap_now) + $urandom_range(1, 5000);
          5: stamp = now_us - span;
          6: send_read();
          default: send_item(necir_pkg::MODE_RESET, lvl, stamp, 1'b0, 1'b0, '0);
        endcase
      end
      now_us = stamp;
      send_edge(lvl, stamp);
    end
  endtask

  task automatic send_repeat();
    int n;
    now_us = now_us + $urandom_range(15000, 150000);
    send_edge(1'b0, now_us);
    now_us = now_us + $urandom_range(32'(necir_pkg::LEAD_MARK_LO) + 1,
                                     32'(necir_pkg::LEAD_MARK_HI) - 1);
    send_edge(1'b1, now_us);
    now_us = now_us + $urandom_range(32'(necir_pkg::RPT_SPACE_LO) + 1,
                                     32'(necir_pkg::RPT_SPACE_HI) - 1);
    send_edge(1'b0, now_us);
    for (n = $urandom_range(1, 4); n > 0; n--) begin
      now_us = now_us + $urandom_range(32'(necir_pkg::SHORT_LO) + 1,
                                       32'(necir_pkg::SHORT_HI) - 1);
      send_edge(n[0], now_us);
    end
  endtask

  task automatic send_noise();
    int          n;
    logic [1:0]  mode;
    logic [31:0] stamp;
    for (n = $urandom_range(1, 6); n > 0; n--) begin
      mode = 2'($urandom_range(0, 3));
      stamp = $urandom_range(0, 1) ? $urandom : now_us + $urandom_range(0, 12000);
      if (mode == necir_pkg::MODE_EDGE) now_us = stamp;
      send_item(mode, 1'($urandom_range(0, 1)), stamp, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic run_episode();
    int         pick;
    logic [7:0] cmd;
    logic [7:0] inv;
    pick = $urandom_range(0, 99);
    cmd = 8'($urandom);
    inv = ($urandom_range(0, 3) != 0) ? ~cmd : 8'($urandom);
    if ($urandom_range(0, 3) == 0)
      send_item(necir_pkg::MODE_RESET, 1'($urandom_range(0, 1)), $urandom, 1'b0, 1'b0, '0);
    if ($urandom_range(0, 5) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 80000);
    if (pick < 25) begin
      send_frame({inv, cmd, 16'($urandom)}, -1);
      send_read();
    end else if (pick < 55) begin
      send_repeat();
      send_read();
    end else if (pick < 70) begin
      send_frame({inv, cmd, 16'($urandom)}, $urandom_range(1, 67));
      send_read();
    end else begin
      send_noise();
    end
    if ($urandom_range(0, 4) == 0) send_read();
  endtask

  task automatic squeeze_output();
    int n;
    @(negedge clk);
    in_valid <= 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(negedge clk);
    no_gaps = 1'b1;
    for (n = 0; n < 10; n++) send_read();
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    int                           i;
    int                           p;
    int                           budget;
    logic [necir_pkg::GAP_W-1:0]  limits [0:6];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_mode = necir_pkg::MODE_EDGE;
    in_line_level = 1'b0;
    in_edge_time_us = '0;
    word_typed = 1'b0;
    typed_ok = 1'b0;
    typed_code = '0;
    nec_edges = '0;
    rpt_locked = 1'b0;
    last_stamp = '0;
    code_acc = '0;
    bad_bit = 1'b0;
    gap_now = necir_pkg::GAP_RESET;
    errors = 0;
    words_sent = 0;
    results_checked = 0;
    good_results = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_active = 1'b0;
    limits = '{necir_pkg::GAP_RESET, 20'hFFFFF, 20'd0, 20'd1, 20'd9600,
               20'($urandom_range(10000, 20'hFFFFF)), necir_pkg::GAP_RESET};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++)
      send_item(script[i].mode, script[i].lvl, script[i].stamp,
                script[i].typed, script[i].ok, script[i].code);
    settle();

    now_us = $urandom;
    for (p = 0; p < 7; p++) begin
      if (p > 0) write_gap_limit(limits[p]);
      budget = words_sent + ((limits[p] < 9000) ? 15 : 40);
      while (words_sent < budget) run_episode();
      if (p == 0) squeeze_output();
    end
    while (words_sent < WORDS_TARGET) run_episode();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d words driven, %0d reads checked, %0d returned a good frame or repeat",
             words_sent, results_checked, good_results);
    $display("tb: gap limits 0, 1, 9600, 100000, 1048575 and one random, %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0 && read_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
